@@ rtl/core/ordered_value_list_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OVL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered_value_list: check failed");

// Consequent must hold in the cycle after the antecedent.
`define OVL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered_value_list: check failed");

`endif

@@ rtl/core/ovl_pkg.sv @@
package ovl_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_FRONT  = 2'd0,
		OP_BACK   = 2'd1,
		OP_SEARCH = 2'd2,
		OP_DELETE = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic       full_drop;
		logic [4:0] entry_count;
	} out_item_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic               accept;
		logic               full;
		opcode_t            opcode;
		logic signed [31:0] item_value;
	} ovl_cmd_t;

	// Where a cell stands relative to the list's end.
	typedef struct packed {
		logic active;
		logic at_tail;
	} ovl_pos_t;

endpackage

@@ rtl/core/ovl_cell.sv @@
module ovl_cell
	import ovl_pkg::*;
(
	input  logic               clk,
	input  ovl_cmd_t           cmd,
	input  ovl_pos_t           pos,
	input  logic signed [31:0] prev_value,
	input  logic signed [31:0] next_value,
	input  logic               seen_in,
	output logic               seen_out,
	output logic signed [31:0] value
);

	logic signed [31:0] value_q;
	logic               hit;
	logic               load;
	logic signed [31:0] load_value;

	assign hit      = pos.active && (value_q == cmd.item_value);
	assign seen_out = seen_in || hit;
	assign value    = value_q;

	always_comb begin
		load       = 1'b0;
		load_value = next_value;
		case (cmd.opcode)
			OP_FRONT: begin
				// shift back one place, cell 0 takes the new value
				load       = cmd.accept && !cmd.full && (pos.active || pos.at_tail);
				load_value = prev_value;
			end
			OP_BACK: begin
				load       = cmd.accept && !cmd.full && pos.at_tail;
				load_value = cmd.item_value;
			end
			OP_DELETE: begin
				// close the gap from the first match on
				load       = cmd.accept && pos.active && seen_out;
				load_value = next_value;
			end
			default: begin
				load       = 1'b0;
				load_value = next_value;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= load_value;
		end
	end

endmodule

@@ rtl/core/ordered_value_list.sv @@
// Channel   | Direction | Ports                 | Handshake
// ----------+-----------+-----------------------+------------------------------------
// command   | in        | item (in_item_t)      | start high and busy low at clk edge
// result    | out       | result (out_item_t)   | done high for one cycle, no stall
//
// One transaction per clock cycle: a command accepted at an edge shows its
// result with done in the very next cycle. The figure is set by the cell
// chain, where every cell compares against the command value and the first-
// match flag ripples front to back combinationally. busy stays low.
// arst_n clears the entry count and the done strobe; entry words are only
// read below the count, so they carry no reset. The result side has no stall.
module ordered_value_list
	import ovl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               done_q;
	out_item_t          result_q;
	ovl_cmd_t           cmd;
	ovl_pos_t           pos       [CAPACITY];
	logic signed [31:0] cell_value[CAPACITY];
	logic signed [31:0] prev_word [CAPACITY];
	logic               seen      [CAPACITY+1];
	logic               is_insert;
	logic               is_lookup;
	logic               found;

	// The chain never holds a command back.
	assign busy = 1'b0;

	assign cmd.accept     = start && !busy;
	assign cmd.full       = (count_q == CNT_W'(CAPACITY));
	assign cmd.opcode     = item.opcode;
	assign cmd.item_value = item.item_value;

	assign is_insert = (item.opcode == OP_FRONT) || (item.opcode == OP_BACK);
	assign is_lookup = (item.opcode == OP_SEARCH) || (item.opcode == OP_DELETE);

	// First-match flag enters the front of the chain clear.
	assign seen[0] = 1'b0;
	assign found   = seen[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign pos[i].active  = (count_q > CNT_W'(i));
		assign pos[i].at_tail = (count_q == CNT_W'(i));

		// Cell 0 has no front neighbor: on insert front it takes the command value.
		if (i == 0) begin : g_head
			assign prev_word[i] = item.item_value;
		end else begin : g_body
			assign prev_word[i] = cell_value[i-1];
		end

		ovl_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (pos[i]),
			.prev_value(prev_word[i]),
			.next_value(cell_value[(i == CAPACITY - 1) ? i : i + 1]),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1]),
			.value     (cell_value[i])
		);
	end

	always_comb begin
		count_next = count_q;
		case (item.opcode)
			OP_FRONT, OP_BACK: begin
				if (!cmd.full) begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	// Advance the count and raise done for each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.accept;
			if (cmd.accept) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			result_q.found       <= is_lookup && found;
			result_q.full_drop   <= is_insert && cmd.full;
			result_q.entry_count <= 5'(count_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/ovl_checker.sv @@
`include "ordered_value_list_macros.svh"

module ovl_checker
	import ovl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	// Every accepted transaction yields exactly one result, in the next cycle.
	`OVL_ASSERT_NEXT(a_done_after_accept, start && !busy, done)
	`OVL_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
	// A dropped insert only happens on a full list and never reports a hit.
	`OVL_ASSERT_NOW(a_drop_not_found, done && result.full_drop, !result.found)
	`OVL_ASSERT_NOW(a_drop_when_full, done && result.full_drop, result.entry_count == 5'(CAPACITY))

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (.*);

@@ tb/ordered_value_list_test.sv @@
`timescale 1ns / 100ps

module ordered_value_list_test;
	import ovl_pkg::*;

	// Bias of the random traffic: lean toward inserts, toward removals, or neither.
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	localparam int POOL_N = 10;
	localparam int RECENT_MAX = 32;
	localparam int RANDOM_OPS = 1700;
	localparam int TAIL_CYCLES = 4;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_item_t  item = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	// Commands waiting to go out, and results owed by the block, oldest first.
	in_item_t  pending_ops[$];
	out_item_t owed_results[$];

	// Software image of the list: values front to back and how many are held.
	logic signed [31:0] list_vals [CAPACITY];
	int                 list_len = 0;

	// Values the generator inserted lately, reused so lookups hit often.
	logic signed [31:0] recent_vals[$];
	logic signed [31:0] value_pool [POOL_N];

	int        gap_left = 0;
	int        burst_left = 0;
	int        gap_roll;
	int        error_count = 0;
	out_item_t want;

	ordered_value_list u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one command to the list image and return the result the block owes.
	function automatic out_item_t apply_list_op(in_item_t cmd);
		out_item_t r;
		int        hit;
		r = '0;
		hit = -1;
		// Scan only the held entries; the first match from the front wins.
		for (int i = 0; i < list_len; i++) begin
			if (hit < 0 && list_vals[i] == cmd.item_value)
				hit = i;
		end
		case (cmd.opcode)
			OP_FRONT: begin
				if (list_len >= CAPACITY) begin
					r.full_drop = 1'b1;
				end else begin
					for (int i = list_len; i > 0; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[0] = cmd.item_value;
					list_len++;
				end
			end
			OP_BACK: begin
				if (list_len >= CAPACITY) begin
					r.full_drop = 1'b1;
				end else begin
					list_vals[list_len] = cmd.item_value;
					list_len++;
				end
			end
			OP_SEARCH: begin
				r.found = (hit >= 0);
			end
			OP_DELETE: begin
				// Close the gap behind the removed entry.
				if (hit >= 0) begin
					for (int i = hit; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
					r.found = 1'b1;
				end
			end
		endcase
		r.entry_count = 5'(list_len);
		return r;
	endfunction

	// Queue one command; remember inserted values for later lookups.
	task automatic queue_op(opcode_t op, logic signed [31:0] value);
		in_item_t cmd;
		cmd.opcode = op;
		cmd.item_value = value;
		pending_ops.push_back(cmd);
		if (op == OP_FRONT || op == OP_BACK) begin
			recent_vals.push_back(value);
			if (recent_vals.size() > RECENT_MAX)
				void'(recent_vals.pop_front());
		end
	endtask

	// Lookups mostly reuse recent inserts; everything else comes from a pool
	// of corner values or from the full 32-bit range.
	function automatic logic signed [31:0] draw_value(bit lookup);
		int roll;
		roll = $urandom_range(0, 99);
		if (lookup && recent_vals.size() > 0 && roll < 60)
			return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
		if (roll < 85)
			return value_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom();
	endfunction

	// Stimulus: directed corner cases, then biased random traffic; reset, then
	// wait for the block to drain and report.
	initial begin
		mix_t mix;
		int   mix_left;
		int   insert_pct;
		int   roll;

		mix = MIX_EVEN;
		mix_left = 0;
		value_pool = '{32'sd0, 32'sd1, 32'sd2, -32'sd1, -32'sd2,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'shAAAA_AAAA, $urandom(), $urandom()};

		// Lookups on an empty list.
		queue_op(OP_SEARCH, 32'sd0);
		queue_op(OP_DELETE, 32'sd0);
		// Extreme values at both ends.
		queue_op(OP_FRONT, 32'sh8000_0000);
		queue_op(OP_BACK, 32'sh7FFF_FFFF);
		queue_op(OP_FRONT, -32'sd1);
		queue_op(OP_BACK, 32'sd0);
		queue_op(OP_SEARCH, 32'sh7FFF_FFFF);
		// Duplicate: delete must take only the copy nearest the front.
		queue_op(OP_BACK, -32'sd1);
		queue_op(OP_DELETE, -32'sd1);
		queue_op(OP_SEARCH, -32'sd1);
		// Delete with no match.
		queue_op(OP_DELETE, 32'sd5);
		// Fill to capacity, then try both inserts on a full list.
		for (int i = 6; i < CAPACITY + 2; i++) begin
			if (i[0])
				queue_op(OP_FRONT, 32'shAAAA_AAAA ^ i);
			else
				queue_op(OP_BACK, 32'sh5555_5555 ^ i);
		end
		queue_op(OP_FRONT, 32'sd7);
		queue_op(OP_BACK, 32'sd8);

		// Random part: swing between filling and draining phases so the list
		// visits empty, full and everything in between.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (mix_left == 0) begin
				roll = $urandom_range(0, 2);
				mix = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
				mix_left = $urandom_range(20, 60);
			end
			mix_left--;
			insert_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
			roll = $urandom_range(0, 99);
			if (roll < insert_pct) begin
				if ($urandom_range(0, 1))
					queue_op(OP_FRONT, draw_value(1'b0));
				else
					queue_op(OP_BACK, draw_value(1'b0));
			end else begin
				if ($urandom_range(0, 1))
					queue_op(OP_SEARCH, draw_value(1'b1));
				else
					queue_op(OP_DELETE, draw_value(1'b1));
			end
		end

		// Hold reset, then release it on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every command is out and every result is back.
		while (pending_ops.size() != 0 || start || owed_results.size() != 0)
			@(posedge clk);
		// Keep watching after the drain to catch a stray strobe.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ordered_value_list test passed");
		else
			$display("ordered_value_list test failed");
		$finish;
	end

	// Driver: present commands from the queue with random idle gaps. A
	// transaction completes at an edge with start high and busy low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				owed_results.push_back(apply_list_op(item));
				// Pick the idle gap before the next command: mostly none or
				// short, a few long, and now and then a run with no gaps at all.
				gap_roll = $urandom_range(0, 99);
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else if (gap_roll < 2) begin
					burst_left = $urandom_range(30, 80);
					gap_left = 0;
				end else if (gap_roll < 55) begin
					gap_left = 0;
				end else if (gap_roll < 88) begin
					gap_left = $urandom_range(1, 3);
				end else if (gap_roll < 98) begin
					gap_left = $urandom_range(4, 10);
				end else begin
					gap_left = $urandom_range(20, 60);
				end
			end
			// Hold a command the block has not taken; otherwise idle or advance.
			if (start && busy) begin
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				item <= pending_ops.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result must match the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing owed: found %b full_drop %b entry_count %0d",
					$time, result.found, result.full_drop, result.entry_count);
				error_count++;
			end else begin
				want = owed_results.pop_front();
				if (result.found !== want.found) begin
					$display("%0t: found expected %b actual %b",
						$time, want.found, result.found);
					error_count++;
				end
				if (result.full_drop !== want.full_drop) begin
					$display("%0t: full_drop expected %b actual %b",
						$time, want.full_drop, result.full_drop);
					error_count++;
				end
				if (result.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, want.entry_count, result.entry_count);
					error_count++;
				end
			end
		end
	end

	// Drop the run if it hangs.
	initial begin
		#2_000_000;
		$display("ordered_value_list test failed");
		$finish;
	end

endmodule

@@ ordered_value_list.f @@
+incdir+rtl/core
rtl/core/ovl_pkg.sv
rtl/core/ovl_cell.sv
rtl/core/ordered_value_list.sv
rtl/core/ovl_checker.sv
tb/ordered_value_list_test.sv
